@@ rtl/lfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_pkg
// Shared types and codes of the frame replacer: transfer payloads and
// operation codes.
// ----------------------------------------------------------------------------
package lfr_pkg;

    localparam int OP_WIDTH    = 2;
    localparam int FRAME_WIDTH = 6;
    localparam int COUNT_WIDTH = 7;

    localparam logic [OP_WIDTH-1:0] OP_VICTIM = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_PIN    = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_UNPIN  = 2'd2;

    typedef struct packed {
        logic [OP_WIDTH-1:0]    operation;
        logic [FRAME_WIDTH-1:0] frame;
    } t_in_item;

    typedef struct packed {
        logic                   ok;
        logic [FRAME_WIDTH-1:0] victim_frame;
        logic [COUNT_WIDTH-1:0] evictable_count;
    } t_out_item;

endpackage
`default_nettype wire

@@ rtl/lfr_entry_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_entry_ram
// Frame entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lfr_entry_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 34,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/lru_frame_replacer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lru_frame_replacer
// Buffer-pool frame replacer, least recently unpinned frame is the victim.
// ----------------------------------------------------------------------------
// Each frame's present bit, pinned bit and unpin stamp live in one entry
// memory with a single read and a single write port. After reset the block
// runs a clearing pass over every entry with o_in_stall high. It then
// handles one item at a time: a pin, an unpin, an out-of-range frame or the
// unused code has its entry read at the input transfer, then S_UPDATE writes
// back a pin or unpin and registers the result; a victim request reads every
// entry once through the read port in S_SCAN and registers its result in
// S_EVICT. A new item is taken while the previous result still waits in the
// output register; the result stage holds while that register is full and
// i_out_stall is high.
module lru_frame_replacer #(
    parameter int NUM_FRAMES  = 64,
    parameter int STAMP_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire lfr_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output lfr_pkg::t_out_item       o_out_data
);

    localparam int FW  = $clog2(NUM_FRAMES);
    localparam int CW  = $clog2(NUM_FRAMES + 1);
    localparam int EW  = STAMP_WIDTH + 2;
    localparam int AXW = (FW > lfr_pkg::FRAME_WIDTH) ? FW : lfr_pkg::FRAME_WIDTH;
    localparam int CXW = (CW > lfr_pkg::COUNT_WIDTH) ? CW : lfr_pkg::COUNT_WIDTH;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_EVICT
    } t_state;

    t_state                  r_state, n_state;
    logic [FW:0]             r_addr, n_addr;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [STAMP_WIDTH-1:0]  r_use, n_use;
    logic                    r_out_valid, n_out_valid;

    lfr_pkg::t_out_item      r_out, n_out;
    logic [FW-1:0]           r_idx, n_idx;
    logic                    r_active, n_active;
    logic [lfr_pkg::OP_WIDTH-1:0] r_op, n_op;
    logic [FW-1:0]           r_data_idx, n_data_idx;
    logic                    r_found, n_found;
    logic [STAMP_WIDTH-1:0]  r_best, n_best;
    logic [FW-1:0]           r_best_idx, n_best_idx;

    logic                    ram_we, ram_re;
    logic [FW-1:0]           ram_waddr, ram_raddr;
    logic [EW-1:0]           ram_wdata, ram_rdata;

    logic                    out_free;
    logic                    accept;
    logic [AXW-1:0]          frame_ext;
    logic                    in_range;
    logic                    e_present, e_pinned;
    logic [STAMP_WIDTH-1:0]  e_stamp;
    logic [STAMP_WIDTH-1:0]  use_next;
    logic                    cand, take;
    logic [CXW-1:0]          cnt_ext;
    logic [AXW-1:0]          best_ext;

    lfr_entry_ram #(
        .DEPTH (NUM_FRAMES),
        .WIDTH (EW),
        .AW    (FW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign frame_ext  = AXW'(i_in_data.frame);
    assign in_range   = (32'(i_in_data.frame) < NUM_FRAMES);

    assign e_present = ram_rdata[EW-1];
    assign e_pinned  = ram_rdata[EW-2];
    assign e_stamp   = ram_rdata[STAMP_WIDTH-1:0];
    // stamp counter saturates instead of wrapping
    assign use_next  = (r_use == '1) ? r_use : r_use + 1'b1;

    assign cand     = e_present && !e_pinned;
    assign take     = cand && (!r_found || (e_stamp < r_best));
    assign best_ext = AXW'(r_best_idx);

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        n_use       = r_use;
        n_out_valid = out_free ? 1'b0 : r_out_valid;
        n_out       = r_out;
        n_idx       = r_idx;
        n_active    = r_active;
        n_op        = r_op;
        n_data_idx  = r_data_idx;
        n_found     = r_found;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        ram_we      = 1'b0;
        ram_waddr   = r_addr[FW-1:0];
        ram_wdata   = '0;
        ram_re      = 1'b0;
        ram_raddr   = r_addr[FW-1:0];
        cnt_ext     = '0;

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr[FW-1:0];
                ram_wdata = '0;
                n_addr    = r_addr + 1'b1;
                if (r_addr == (FW+1)'(NUM_FRAMES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op = i_in_data.operation;
                    if (i_in_data.operation == lfr_pkg::OP_VICTIM) begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        n_addr     = (FW+1)'(1);
                        n_data_idx = '0;
                        n_found    = 1'b0;
                        n_best     = '0;
                        n_best_idx = '0;
                        n_state    = S_SCAN;
                    end else begin
                        n_active = in_range && ((i_in_data.operation == lfr_pkg::OP_PIN)
                                             || (i_in_data.operation == lfr_pkg::OP_UNPIN));
                        n_idx     = frame_ext[FW-1:0];
                        ram_re    = 1'b1;
                        ram_raddr = frame_ext[FW-1:0];
                        n_state   = S_UPDATE;
                    end
                end
            end
            S_UPDATE: begin
                if (out_free) begin
                    n_out.ok           = 1'b0;
                    n_out.victim_frame = '0;
                    if (r_active && (r_op == lfr_pkg::OP_PIN)) begin
                        if (cand) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_idx;
                            ram_wdata = {1'b1, 1'b1, e_stamp};
                            if (r_cnt != '0) begin
                                n_cnt = r_cnt - 1'b1;
                            end
                            n_out.ok = 1'b1;
                        end
                    end else if (r_active) begin
                        if (!cand) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_idx;
                            ram_wdata = {1'b1, 1'b0, use_next};
                            n_use     = use_next;
                            n_cnt     = r_cnt + 1'b1;
                            n_out.ok  = 1'b1;
                        end
                    end
                    cnt_ext               = CXW'(n_cnt);
                    n_out.evictable_count = cnt_ext[lfr_pkg::COUNT_WIDTH-1:0];
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            S_SCAN: begin
                n_found = r_found || cand;
                if (take) begin
                    n_best     = e_stamp;
                    n_best_idx = r_data_idx;
                end
                if (r_addr == (FW+1)'(NUM_FRAMES)) begin
                    n_state = S_EVICT;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = r_addr[FW-1:0];
                    n_addr     = r_addr + 1'b1;
                    n_data_idx = r_addr[FW-1:0];
                end
            end
            S_EVICT: begin
                if (out_free) begin
                    n_out.ok           = r_found;
                    n_out.victim_frame = '0;
                    if (r_found) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_best_idx;
                        ram_wdata = '0;
                        if (r_cnt != '0) begin
                            n_cnt = r_cnt - 1'b1;
                        end
                        n_out.victim_frame = best_ext[lfr_pkg::FRAME_WIDTH-1:0];
                    end
                    cnt_ext               = CXW'(n_cnt);
                    n_out.evictable_count = cnt_ext[lfr_pkg::COUNT_WIDTH-1:0];
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_cnt       <= '0;
            r_use       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_cnt       <= n_cnt;
            r_use       <= n_use;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_idx      <= n_idx;
        r_active   <= n_active;
        r_op       <= n_op;
        r_data_idx <= n_data_idx;
        r_found    <= n_found;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire
